// File: rtl/core/sorted_priority_queue_unit_macros.svh
// ---------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property wrappers, sampled on clk and quiet while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// plain implication check
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal must not move while the condition holds into the next edge
`define SPQ_ASSERT_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// shared sizes, codes and types of the sorted priority queue
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int VALUE_BITS    = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
    localparam int LIMIT_BITS    = 5;
    localparam int LIMIT_RESET   = 16;
    localparam int STATUS_BITS   = 2;
    localparam int CMD_BITS      = 2;
    localparam int TDATA_BITS    = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_DISPLAY = 2'd2
    } cmd_t;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } state_t;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [VALUE_BITS-1:0]    value;
    } entry_t;

    // broadcast to every cell each cycle
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
        entry_t   head;
    } cell_ctrl_t;

endpackage

// File: rtl/core/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry and trades with its neighbors
// ---------------------------------------------------------------------------
module spq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     left_entry,
    input  logic                left_occ,
    input  logic                left_keep,
    input  spq_pkg::entry_t     right_entry,
    input  logic                right_occ,
    output spq_pkg::entry_t     entry,
    output logic                occ,
    output logic                keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occ_reg;
    logic            occ_next;

    // entry stays put on insert: it ranks at or above the newcomer
    assign keep  = occ_reg && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry = entry_reg;
    assign occ   = occ_reg;

    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        unique case (ctrl.op)
            spq_pkg::OP_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        entry_next = ctrl.new_entry;
                        occ_next   = 1'b1;
                    end
                    else
                    begin
                        entry_next = left_entry;
                        occ_next   = left_occ;
                    end
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                entry_next = right_entry;
                occ_next   = right_occ;
            end
            spq_pkg::OP_ROTATE:
            begin
                // last live slot wraps the head around
                if (right_occ)
                begin
                    entry_next = right_entry;
                end
                else if (occ_reg)
                begin
                    entry_next = ctrl.head;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/core/sorted_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_unit
// bounded priority queue held sorted in a chain of cells, highest at the head
// ---------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser command, tdata value+prio
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser status, tdata value+prio,
//                                                tlast final beat of a command
//  cfg       in   cfg_we                         cfg_wdata queue limit
//
//  insert and delete can be accepted every cycle while the output register
//  drains; the whole chain shifts as the command is accepted
//  display sends one beat per live entry and takes no new input until done, the
//  chain rotating its live part by one slot for each beat sent
//  reset clears the occupancy flags and the count, the limit returns to 16
//  a stalled m_axis holds the result in place and stops new input beats
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] item_value, [47:32] item_priority
    input  logic [spq_pkg::TDATA_BITS-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [spq_pkg::CMD_BITS-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] out_value, [47:32] out_priority
    output logic [spq_pkg::TDATA_BITS-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [spq_pkg::STATUS_BITS-1:0] m_axis_tuser,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [spq_pkg::LIMIT_BITS-1:0]  cfg_wdata
);

    localparam int N = spq_pkg::CAPACITY;

    // control state
    spq_pkg::state_t                  state_reg, state_next;
    logic [spq_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic [spq_pkg::COUNT_BITS-1:0]   remain_reg, remain_next;
    logic [spq_pkg::LIMIT_BITS-1:0]   limit_reg;

    // output register
    logic                             m_valid_reg, m_valid_next;
    logic [spq_pkg::STATUS_BITS-1:0]  m_status_reg, m_status_next;
    spq_pkg::entry_t                  m_entry_reg, m_entry_next;
    logic                             m_last_reg, m_last_next;

    // chain wiring
    spq_pkg::cell_ctrl_t              ctrl;
    spq_pkg::entry_t                  cell_entry [N];
    logic [N-1:0]                     cell_occ;
    logic [N-1:0]                     cell_keep;

    spq_pkg::entry_t                  in_entry;
    spq_pkg::cmd_t                    in_cmd;
    logic                             out_free;
    logic                             in_beat;
    logic                             is_full;
    logic                             is_empty;
    logic [31:0]                      count_w;
    logic [31:0]                      limit_w;

    assign in_entry.value = s_axis_tdata[spq_pkg::VALUE_BITS-1:0];
    assign in_entry.prio  = s_axis_tdata[spq_pkg::VALUE_BITS +: spq_pkg::PRIORITY_BITS];
    assign in_cmd         = spq_pkg::cmd_t'(s_axis_tuser);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == spq_pkg::ST_IDLE) && out_free;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // a limit above capacity acts as capacity, zero refuses every insert
    assign count_w  = 32'(count_reg);
    assign limit_w  = 32'(limit_reg);
    assign is_full  = (count_w >= limit_w) || (count_w >= 32'(N));
    assign is_empty = (count_reg == '0);

    // the row of cells, slot 0 is the head
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        spq_pkg::entry_t l_entry;
        spq_pkg::entry_t r_entry;
        logic            l_occ;
        logic            l_keep;
        logic            r_occ;

        if (i == 0)
        begin : g_head
            assign l_entry = '0;
            assign l_occ   = 1'b0;
            assign l_keep  = 1'b1;
        end
        else
        begin : g_mid
            assign l_entry = cell_entry[i-1];
            assign l_occ   = cell_occ[i-1];
            assign l_keep  = cell_keep[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign r_entry = '0;
            assign r_occ   = 1'b0;
        end
        else
        begin : g_inner
            assign r_entry = cell_entry[i+1];
            assign r_occ   = cell_occ[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_entry  (l_entry),
            .left_occ    (l_occ),
            .left_keep   (l_keep),
            .right_entry (r_entry),
            .right_occ   (r_occ),
            .entry       (cell_entry[i]),
            .occ         (cell_occ[i]),
            .keep        (cell_keep[i])
        );
    end

    // command sequencing and result formation
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_status_next  = m_status_reg;
        m_entry_next   = m_entry_reg;
        m_last_next    = m_last_reg;
        ctrl.op        = spq_pkg::OP_HOLD;
        ctrl.new_entry = in_entry;
        ctrl.head      = cell_entry[0];

        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    unique case (in_cmd)
                        spq_pkg::CMD_INSERT:
                        begin
                            m_valid_next  = 1'b1;
                            m_entry_next  = '0;
                            m_last_next   = 1'b1;
                            if (is_full)
                            begin
                                m_status_next = spq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                m_status_next = spq_pkg::STATUS_OK;
                                ctrl.op       = spq_pkg::OP_INSERT;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        spq_pkg::CMD_DELETE:
                        begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (is_empty)
                            begin
                                m_status_next = spq_pkg::STATUS_EMPTY;
                                m_entry_next  = '0;
                            end
                            else
                            begin
                                m_status_next = spq_pkg::STATUS_OK;
                                m_entry_next  = cell_entry[0];
                                ctrl.op       = spq_pkg::OP_REMOVE;
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        spq_pkg::CMD_DISPLAY:
                        begin
                            if (is_empty)
                            begin
                                m_valid_next  = 1'b1;
                                m_status_next = spq_pkg::STATUS_EMPTY;
                                m_entry_next  = '0;
                                m_last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next  = spq_pkg::ST_SHOW;
                                remain_next = count_reg;
                            end
                        end
                        default:
                        begin
                            // unused code: beat taken, nothing produced
                            state_next = spq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            spq_pkg::ST_SHOW:
            begin
                // send the head, then rotate the live slots by one
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = spq_pkg::STATUS_OK;
                    m_entry_next  = cell_entry[0];
                    m_last_next   = (remain_reg == spq_pkg::COUNT_BITS'(1));
                    ctrl.op       = spq_pkg::OP_ROTATE;
                    remain_next   = remain_reg - 1'b1;
                    if (remain_reg == spq_pkg::COUNT_BITS'(1))
                    begin
                        state_next = spq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= spq_pkg::ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= spq_pkg::LIMIT_BITS'(spq_pkg::LIMIT_RESET);
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_entry_reg  <= m_entry_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = spq_pkg::TDATA_BITS'({m_entry_reg.prio, m_entry_reg.value});

endmodule

// File: rtl/core/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// port-level checks on the sorted priority queue, bound to the top level
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_unit_macros.svh"

module spq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spq_pkg::TDATA_BITS-1:0]  m_axis_tdata,
    input logic [spq_pkg::STATUS_BITS-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic stalled;
    logic refusal;
    logic zero_last;

    assign stalled   = m_axis_tvalid && !m_axis_tready;
    assign refusal   = m_axis_tvalid && (m_axis_tuser == spq_pkg::STATUS_FULL ||
                                         m_axis_tuser == spq_pkg::STATUS_EMPTY);
    assign zero_last = m_axis_tlast && (m_axis_tdata == '0);

    `SPQ_ASSERT(a_valid_held, stalled |=> m_axis_tvalid, "m_axis beat dropped while stalled")
    `SPQ_ASSERT_HOLD(a_data_held, stalled, m_axis_tdata, "m_axis data moved while stalled")
    `SPQ_ASSERT(a_refusal_last, refusal |-> zero_last, "full or empty beat must be a lone zero beat")
    `SPQ_ASSERT(a_no_input_while_busy, stalled |-> !s_axis_tready, "input ready while stalled")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
